// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the result-channel checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/oal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg
// Types and constants shared by the ordered array list and its cells.
// ----------------------------------------------------------------------------
package oal_pkg;

    // list capacity
    localparam int DEPTH = 16;

    // widths
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [CMP_W-1:0]         cmp_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } op_t;

    // control states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } st_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  ins;
        logic  del;
        idx_t  idx;
        word_t value;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/oal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds a word, shifts from a neighbor on insert or delete,
// and compares its word against the broadcast value.
// ----------------------------------------------------------------------------
module oal_cell
    import oal_pkg::*;
(
    input  logic      aclk,
    input  idx_t      cell_idx,
    input  cell_ctl_t ctl,
    input  word_t     left_word,
    input  word_t     right_word,
    output word_t     word,
    output logic      match
);

    word_t word_reg;
    word_t word_next;

    // slot update: load, take from the lower slot, or take from the upper slot
    always_comb begin
        word_next = word_reg;
        if (ctl.ins) begin
            if (cell_idx == ctl.idx) begin
                word_next = ctl.value;
            end else if (cell_idx > ctl.idx) begin
                word_next = left_word;
            end
        end else if (ctl.del && (cell_idx >= ctl.idx)) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // local compare for locate
    assign word  = word_reg;
    assign match = (word_reg == ctl.value);

endmodule

// ===== hw/rtl/ordered_array_list.sv =====
// Insert, delete and get: the result is loaded into the output register as the item is
// accepted; one item per cycle while the result side keeps taking them.
// Locate: the result comes from the one-slot-per-cycle scan over the registered match
// flags, which stops at the first match or the last slot; no item is taken meanwhile.
// Synchronous active-low reset empties the list; slot words are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list
// Ordered list of signed words built as a row of shifting cells.
// ----------------------------------------------------------------------------
module ordered_array_list
    import oal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [WORD_W-1:0] m_word_out,
    output logic [POS_W-1:0]         m_found_position,
    output logic [POS_W-1:0]         m_count
);

    st_t  state_reg, state_next;
    len_t len_reg, len_next;
    idx_t scan_idx_reg, scan_idx_next;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] cell_match;
    word_t cell_word [DEPTH];

    logic             m_valid_reg;
    logic             m_ok_reg;
    word_t            m_word_reg;
    logic [POS_W-1:0] m_pos_reg;
    logic [POS_W-1:0] m_count_reg;

    op_t       op;
    cmp_t      pos_ext, len_ext;
    idx_t      acc_idx;
    logic      accept, ins_ok, rd_ok;
    logic      scan_hit, scan_last, scan_done;
    logic      load_imm;
    logic      imm_ok;
    word_t     imm_word;
    word_t     rd_word;
    cell_ctl_t ctl;

    // request decode
    assign op      = op_t'(s_operation);
    assign pos_ext = CMP_W'(s_position);
    assign len_ext = CMP_W'(len_reg);
    assign acc_idx = IDX_W'(pos_ext - CMP_W'(1));
    assign accept  = s_valid && s_ready;
    assign ins_ok  = (s_position != '0) && (pos_ext <= len_ext + CMP_W'(1))
                     && (len_ext < CMP_W'(DEPTH));
    assign rd_ok   = (s_position != '0) && (pos_ext <= len_ext);
    assign rd_word = cell_word[acc_idx];

    // broadcast to the cells
    always_comb begin
        ctl.ins   = accept && (op == OP_INSERT) && ins_ok;
        ctl.del   = accept && (op == OP_DELETE) && rd_ok;
        ctl.idx   = acc_idx;
        ctl.value = s_value;
    end

    // row of cells, each fed by its neighbors (zero past either end)
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_word[i+1];
        end
        oal_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (idx_t'(i)),
            .ctl        (ctl),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .match      (cell_match[i])
        );
    end

    // result of an item that finishes at acceptance
    always_comb begin
        imm_ok   = 1'b0;
        imm_word = '0;
        len_next = len_reg;
        case (op)
            OP_INSERT: begin
                imm_ok = ins_ok;
                if (ins_ok) begin
                    len_next = len_reg + len_t'(1);
                end
            end
            OP_DELETE: begin
                imm_ok = rd_ok;
                if (rd_ok) begin
                    imm_word = rd_word;
                    len_next = len_reg - len_t'(1);
                end
            end
            OP_GET: begin
                imm_ok = rd_ok;
                if (rd_ok) begin
                    imm_word = rd_word;
                end
            end
            default: begin
                imm_ok = 1'b0;
            end
        endcase
    end

    // scan status
    assign scan_hit  = match_reg[scan_idx_reg];
    assign scan_last = (CMP_W'(scan_idx_reg) + CMP_W'(1)) == len_ext;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (op == OP_LOCATE) && (len_reg != '0)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready       = 1'b0;
        scan_done     = 1'b0;
        load_imm      = 1'b0;
        scan_idx_next = scan_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = !m_valid_reg || m_ready;
                load_imm      = s_valid && s_ready
                                && ((op != OP_LOCATE) || (len_reg == '0));
                scan_idx_next = '0;
            end
            ST_SCAN: begin
                scan_done     = scan_hit || scan_last;
                scan_idx_next = scan_idx_reg + idx_t'(1);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                len_reg <= len_next;
            end
            if (load_imm || scan_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan pointer, match flags and result payload
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        if (accept && (op == OP_LOCATE)) begin
            match_reg <= cell_match;
        end
        if (load_imm) begin
            m_ok_reg    <= imm_ok;
            m_word_reg  <= imm_word;
            m_pos_reg   <= '0;
            m_count_reg <= POS_W'(len_next);
        end else if (scan_done) begin
            m_ok_reg    <= scan_hit;
            m_word_reg  <= '0;
            m_pos_reg   <= scan_hit ? POS_W'(CMP_W'(scan_idx_reg) + CMP_W'(1)) : '0;
            m_count_reg <= POS_W'(len_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_word_out       = m_word_reg;
    assign m_found_position = m_pos_reg;
    assign m_count          = m_count_reg;

endmodule

// ===== hw/rtl/oal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_checker
// Port-level checks on the ordered array list result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oal_checker
    import oal_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_ok,
    input logic signed [WORD_W-1:0] m_word_out,
    input logic [POS_W-1:0]         m_found_position,
    input logic [POS_W-1:0]         m_count
);

    // a stalled item stays offered
    `OAL_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "item dropped while stalled")

    // a stalled item keeps its payload
    `OAL_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_ok) && $stable(m_word_out) && $stable(m_found_position) && $stable(m_count), "payload changed while stalled")

    // a failed operation carries no word and no position
    `OAL_ASSERT_SAME(a_fail_clean, aclk, aresetn, m_valid && !m_ok, (m_word_out == '0) && (m_found_position == '0), "failed item carries data")

    // a found position always reports success and no word
    `OAL_ASSERT_SAME(a_found_ok, aclk, aresetn, m_valid && (m_found_position != '0), m_ok && (m_word_out == '0), "found position without success")

endmodule

bind ordered_array_list oal_checker u_oal_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_ok             (m_ok),
    .m_word_out       (m_word_out),
    .m_found_position (m_found_position),
    .m_count          (m_count)
);

// ===== sim/ordered_array_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_checker
// Watches both channels of the ordered list, keeps its own copy of the list
// contents, works out the reply for every accepted item and compares each
// delivered reply field by field, oldest first.
// ----------------------------------------------------------------------------
module ordered_array_list_checker
    import oal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_ok,
    input  logic signed [WORD_W-1:0] m_word_out,
    input  logic [POS_W-1:0]         m_found_position,
    input  logic [POS_W-1:0]         m_count,
    output int                       fail_count,
    output int                       pending,
    output int                       replies_checked,
    output int                       full_refusals,
    output int                       locate_hits,
    output logic [POS_W-1:0]         list_len
);

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic             ok;
        word_t            word;
        logic [POS_W-1:0] found;
        logic [POS_W-1:0] count;
    } reply_t;

    // shadow copy of the list
    word_t  slots [DEPTH];
    int     length;
    reply_t reply_q [$];

    // apply one operation to the shadow list and return its reply
    function automatic reply_t apply_item(op_t op, logic [POS_W-1:0] pos, word_t val);
        reply_t r;
        int     p;
        bit     hit;
        r   = '0;
        p   = pos;
        hit = 1'b0;
        case (op)
            OP_INSERT: begin
                if (length >= DEPTH) begin
                    full_refusals++;
                end else if (p >= 1 && p <= length + 1) begin
                    for (int j = length; j >= p; j--)
                        slots[j] = slots[j-1];
                    slots[p-1] = val;
                    length++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (p >= 1 && p <= length) begin
                    r.word = slots[p-1];
                    for (int j = p; j < length; j++)
                        slots[j-1] = slots[j];
                    length--;
                    r.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (p >= 1 && p <= length) begin
                    r.word = slots[p-1];
                    r.ok   = 1'b1;
                end
            end
            default: begin
                // first match wins
                for (int j = 0; j < length; j++) begin
                    if (!hit && slots[j] == val) begin
                        hit     = 1'b1;
                        r.ok    = 1'b1;
                        r.found = POS_W'(j + 1);
                    end
                end
                if (hit)
                    locate_hits++;
            end
        endcase
        r.count = POS_W'(length);
        return r;
    endfunction

    // compare one reply field and log a difference
    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_PRINTS)
                $display("%0t: %s differs: expected %0d, got %0d",
                         $time, name, $signed(want), $signed(got));
        end
    endtask

    // reply side first, then the newly accepted item
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            length          = 0;
            fail_count      = 0;
            replies_checked = 0;
            full_refusals   = 0;
            locate_hits     = 0;
            reply_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_PRINTS)
                        $display("%0t: reply with none outstanding: expected nothing, got ok=%0b word=%0d pos=%0d count=%0d",
                                 $time, m_ok, m_word_out, m_found_position, m_count);
                end else begin
                    want = reply_q.pop_front();
                    check_field("ok", WORD_W'(want.ok), WORD_W'(m_ok));
                    check_field("word_out", want.word, m_word_out);
                    check_field("found_position", WORD_W'(want.found), WORD_W'(m_found_position));
                    check_field("count", WORD_W'(want.count), WORD_W'(m_count));
                    replies_checked++;
                end
            end
            if (s_valid && s_ready)
                reply_q.push_back(apply_item(op_t'(s_operation), s_position, s_value));
        end
        pending  <= reply_q.size();
        list_len <= POS_W'(length);
    end

endmodule

// ===== sim/ordered_array_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_test
// Drives the ordered list with a directed sequence and then random fill and
// drain bursts under four idling patterns and one long reply stall; the
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module ordered_array_list_test;
    import oal_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 200;
    localparam int BURST_ITEMS    = 50;
    localparam int BURSTS_PER_SET = 5;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_operation;
    logic [POS_W-1:0]         s_position;
    logic signed [WORD_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_ok;
    logic signed [WORD_W-1:0] m_word_out;
    logic [POS_W-1:0]         m_found_position;
    logic [POS_W-1:0]         m_count;

    int               fail_count;
    int               pending;
    int               replies_checked;
    int               full_refusals;
    int               locate_hits;
    logic [POS_W-1:0] list_len;

    int    tx_idle_pct;
    int    rx_stall_pct;
    int    hold_seq;
    int    cycle_count;
    int    items_sent;
    word_t value_pool [8];

    ordered_array_list u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_word_out       (m_word_out),
        .m_found_position (m_found_position),
        .m_count          (m_count)
    );

    ordered_array_list_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_word_out       (m_word_out),
        .m_found_position (m_found_position),
        .m_count          (m_count),
        .fail_count       (fail_count),
        .pending          (pending),
        .replies_checked  (replies_checked),
        .full_refusals    (full_refusals),
        .locate_hits      (locate_hits),
        .list_len         (list_len)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter and run limit
    initial cycle_count = 0;
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("ordered_array_list: mismatch");
        $finish;
    end

    // reply side: random stalls plus one long hold when asked
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // offer one item, with random gaps ahead of it, and wait for acceptance
    task automatic send_item(op_t op, logic [POS_W-1:0] pos, word_t val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // half from a small pool so duplicates and locate hits are common
    function automatic word_t pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return word_t'($urandom);
    endfunction

    // mostly around the current length, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, int'(list_len) + 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    function automatic op_t pick_op(int ins_pct, int del_pct, int get_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            return OP_INSERT;
        if (roll < ins_pct + del_pct)
            return OP_DELETE;
        if (roll < ins_pct + del_pct + get_pct)
            return OP_GET;
        return OP_LOCATE;
    endfunction

    // alternating fill and drain bursts
    task automatic random_set();
        op_t op;
        for (int b = 0; b < BURSTS_PER_SET; b++) begin
            for (int i = 0; i < BURST_ITEMS; i++) begin
                if (b % 2 == 0)
                    op = pick_op(55, 15, 15);
                else
                    op = pick_op(15, 50, 15);
                send_item(op, pick_position(), pick_value());
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
        hold_seq     <= 0;
        items_sent    = 0;
        s_valid      <= 1'b0;
        s_operation  <= OP_INSERT;
        s_position   <= '0;
        s_value      <= '0;
        aresetn      <= 1'b0;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int i = 5; i < 8; i++)
            value_pool[i] = word_t'($urandom);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: everything fails
        send_item(OP_GET,    5'd1, 0);
        send_item(OP_DELETE, 5'd1, 0);
        send_item(OP_LOCATE, 5'd0, 0);
        send_item(OP_INSERT, 5'd0, 7);
        send_item(OP_INSERT, 5'd2, 7);
        // build [-1, 0, min, max, max]
        send_item(OP_INSERT, 5'd1, 32'sh8000_0000);
        send_item(OP_INSERT, 5'd2, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 5'd1, -1);
        send_item(OP_INSERT, 5'd2, 0);
        send_item(OP_INSERT, 5'd5, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 5'd31, 3);
        // reads inside and just outside the list
        send_item(OP_GET,    5'd1, 0);
        send_item(OP_GET,    5'd5, 0);
        send_item(OP_GET,    5'd6, 0);
        send_item(OP_GET,    5'd0, 0);
        // duplicate returns the first match, absent value misses
        send_item(OP_LOCATE, 5'd0, 32'sh7FFF_FFFF);
        send_item(OP_LOCATE, 5'd0, 32'sh8000_0000);
        send_item(OP_LOCATE, 5'd0, 12345);
        // deletes at head, tail, past the end, zero and middle
        send_item(OP_DELETE, 5'd1, 0);
        send_item(OP_DELETE, 5'd4, 0);
        send_item(OP_DELETE, 5'd4, 0);
        send_item(OP_DELETE, 5'd0, 0);
        send_item(OP_DELETE, 5'd2, 0);
        send_item(OP_LOCATE, 5'd0, 0);

        // no idling, with one long reply hold so the block backs up
        hold_seq <= hold_seq + 1;
        random_set();

        // sender idle
        tx_idle_pct  <= 61;
        rx_stall_pct <= 0;
        random_set();

        // receiver stalling
        tx_idle_pct  <= 0;
        rx_stall_pct <= 61;
        random_set();

        // both
        tx_idle_pct  <= 30;
        rx_stall_pct <= 30;
        random_set();

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items: directed list edges, then fill/drain bursts under four idling patterns",
                 items_sent);
        $display("checked %0d replies; %0d inserts refused on a full list, %0d locates matched",
                 replies_checked, full_refusals, locate_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("ordered_array_list: match");
        end else begin
            $display("ordered_array_list: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/oal_pkg.sv
hw/rtl/oal_cell.sv
hw/rtl/ordered_array_list.sv
hw/rtl/oal_checker.sv
sim/ordered_array_list_checker.sv
sim/ordered_array_list_test.sv
